/* design/pli_pkg.sv */
// Types shared by the piecewise linear interpolator.
// No dependencies; used by every module of the block.
package pli_pkg;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } pli_op_e;

  typedef struct packed {
    pli_op_e            opcode;
    logic [3:0]         point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } pli_in_t;

  typedef struct packed {
    logic signed [31:0] y_result;
    logic               interp_flag;
  } pli_out_t;

  // Query token handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic               done;
    logic               lerp;
    logic               flag;
    logic signed [31:0] xq;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] res;
    logic signed [32:0] dy;
    logic signed [32:0] t;
    logic signed [32:0] dx;
  } pli_tok_t;

endpackage

/* design/piecewise_linear_interp.sv */
// Piecewise linear interpolator: a row of breakpoint cells and a slope unit.
// A match or clamp result is registered in each cell and then in the output
// register; an interpolation also runs the slope unit (multiply, 35-step divide, add),
// skipping the divide when the quotient saturates early.
// One query at a time: the input, loads included, stalls until its result transfers.
// Reset clears control and sets table_length to 1; breakpoints are not cleared.
module piecewise_linear_interp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pli_pkg::pli_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pli_pkg::pli_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_data_i
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (LW > 5) ? LW : 5;

  logic [4:0]        len_q;
  logic              busy_q;
  logic [CW-1:0]     len_ext, eff_len;
  logic [IW-1:0]     last_idx;
  logic              in_xfer, out_xfer;
  pli_pkg::pli_tok_t tok_in;
  pli_pkg::pli_tok_t tok [TABLE_DEPTH+1];

  assign in_stall_o = busy_q;
  assign in_xfer    = in_valid_i && !busy_q;
  assign out_xfer   = out_valid_o && !out_stall_i;

  always_comb begin
    len_ext = CW'(len_q);
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > CW'(TABLE_DEPTH)) begin
      eff_len = CW'(TABLE_DEPTH);
    end else begin
      eff_len = len_ext;
    end
    last_idx = IW'(eff_len - CW'(1));
  end

  always_comb begin
    tok_in       = '0;
    tok_in.valid = in_xfer && (in_data_i.opcode == pli_pkg::OP_QUERY);
    tok_in.xq    = in_data_i.x_value;
    tok_in.flag  = 1'b1;
  end

  assign tok[0] = tok_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= 5'd1;
      busy_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      if (tok_in.valid) begin
        busy_q <= 1'b1;
      end else if (out_xfer) begin
        busy_q <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic wr_en;
    assign wr_en = in_xfer && (in_data_i.opcode == pli_pkg::OP_LOAD)
                   && (32'(in_data_i.point_index) == i);
    pli_cell #(.IDX(i), .IW(IW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en),
      .wr_x_i     (in_data_i.x_value),
      .wr_y_i     (in_data_i.y_value),
      .last_idx_i (last_idx),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  pli_lerp u_lerp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[TABLE_DEPTH]),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/pli_cell.sv */
// One breakpoint cell: holds an x/y pair and evaluates the passing query token.
// Depends on pli_pkg.
module pli_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic signed [31:0] wr_x_i,
  input  logic signed [31:0] wr_y_i,
  input  logic [IW-1:0]     last_idx_i,
  input  pli_pkg::pli_tok_t tok_i,
  output pli_pkg::pli_tok_t tok_o
);

  logic signed [31:0] x_q, y_q;
  pli_pkg::pli_tok_t  tok_d, tok_q;
  logic               valid_q;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.done && (IW'(IDX) <= last_idx_i)) begin
      if (tok_i.xq <= x_q) begin
        tok_d.done = 1'b1;
        if (tok_i.xq == x_q) begin
          tok_d.res  = y_q;
          tok_d.flag = 1'b0;
        end else if (IDX == 0) begin
          tok_d.res  = y_q;
          tok_d.flag = 1'b1;
        end else if (x_q == tok_i.px) begin
          tok_d.res  = tok_i.py;
          tok_d.flag = 1'b1;
        end else begin
          tok_d.lerp = 1'b1;
          tok_d.flag = 1'b1;
          tok_d.res  = tok_i.py;
          tok_d.dy   = {y_q[31], y_q} - {tok_i.py[31], tok_i.py};
          tok_d.t    = {tok_i.xq[31], tok_i.xq} - {tok_i.px[31], tok_i.px};
          tok_d.dx   = {x_q[31], x_q} - {tok_i.px[31], tok_i.px};
        end
      end else if (IW'(IDX) == last_idx_i) begin
        tok_d.done = 1'b1;
        tok_d.res  = y_q;
        tok_d.flag = 1'b1;
      end
      tok_d.px = x_q;
      tok_d.py = y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_d.valid;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

/* design/pli_lerp.sv */
// Slope unit: multiply, bit-serial restoring divide, saturating add, output register.
// Depends on pli_pkg.
module pli_lerp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pli_pkg::pli_tok_t tok_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output pli_pkg::pli_out_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CHK, S_DIV, S_FIN, S_OUT
  } state_e;

  state_e             state_q;
  logic [32:0]        a_q, b_q, c_q, rem_q;
  logic [65:0]        p_q;
  logic [34:0]        sh_q, quo_q;
  logic [5:0]         cnt_q;
  logic               neg_q, valid_q;
  logic signed [31:0] y0_q;
  pli_pkg::pli_out_t  out_q;

  logic [32:0]        a_d, b_d, c_d;
  logic [33:0]        rem_sh;
  logic signed [36:0] sum;

  always_comb begin
    a_d    = tok_i.dy[32] ? 33'(-tok_i.dy) : 33'(tok_i.dy);
    b_d    = tok_i.t[32]  ? 33'(-tok_i.t)  : 33'(tok_i.t);
    c_d    = tok_i.dx[32] ? 33'(-tok_i.dx) : 33'(tok_i.dx);
    rem_sh = {rem_q, sh_q[34]};
    sum    = neg_q ? (37'(y0_q) - $signed({2'b00, quo_q}))
                   : (37'(y0_q) + $signed({2'b00, quo_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (tok_i.valid) begin
            y0_q <= tok_i.res;
            if (tok_i.lerp) begin
              a_q     <= a_d;
              b_q     <= b_d;
              c_q     <= c_d;
              neg_q   <= (tok_i.dy[32] ^ tok_i.t[32]) ^ tok_i.dx[32];
              state_q <= S_MUL;
            end else begin
              out_q.y_result    <= tok_i.res;
              out_q.interp_flag <= tok_i.flag;
              valid_q           <= 1'b1;
              state_q           <= S_OUT;
            end
          end
        end
        S_MUL: begin
          p_q     <= a_q * b_q;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if ({2'b00, p_q[65:35]} >= c_q) begin
            quo_q   <= 35'd1 << 34;
            state_q <= S_FIN;
          end else begin
            rem_q   <= {2'b00, p_q[65:35]};
            sh_q    <= p_q[34:0];
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, c_q}) begin
            rem_q <= 33'(rem_sh - {1'b0, c_q});
            quo_q <= {quo_q[33:0], 1'b1};
          end else begin
            rem_q <= rem_sh[32:0];
            quo_q <= {quo_q[33:0], 1'b0};
          end
          sh_q  <= {sh_q[33:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd34) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (sum > 37'sd2147483647) begin
            out_q.y_result <= 32'sh7FFFFFFF;
          end else if (sum < -37'sd2147483648) begin
            out_q.y_result <= 32'sh80000000;
          end else begin
            out_q.y_result <= sum[31:0];
          end
          out_q.interp_flag <= 1'b1;
          valid_q           <= 1'b1;
          state_q           <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            valid_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/pli_checker.sv */
// Port-level checks for the piecewise linear interpolator, bound to the top level.
// Depends on pli_pkg and piecewise_linear_interp.
module pli_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input pli_pkg::pli_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pli_pkg::pli_out_t out_data_o
);

  // an accepted query is followed by the input stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.opcode == pli_pkg::OP_QUERY) |=> in_stall_o)
    else $error("query not followed by stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result pending while input open");

  // out_valid_o falls after each result transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("extra result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_interp pli_checker u_pli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/piecewise_linear_interp_test.sv */
`timescale 1ns / 1ps
// Regression for piecewise_linear_interp: breakpoint loads, table_length
// settings and queries, checked against a built-in interpolation predictor.
// Depends on pli_pkg and the piecewise_linear_interp RTL only.
module piecewise_linear_interp_test;

  localparam int DEPTH = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  pli_pkg::pli_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pli_pkg::pli_out_t out_data_o;
  logic     cfg_we_i = 1'b0;
  logic [4:0] cfg_data_i = '0;

  piecewise_linear_interp #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  longint   bp_x[DEPTH];
  longint   bp_y[DEPTH];
  int       active_len = 1;
  pli_pkg::pli_out_t pending_results[$];

  int errors = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int results_checked = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint slope_point(longint y0, longint dy, longint t, longint dx);
    logic [67:0] a, b, c, q;
    logic neg;
    a = (dy < 0) ? 68'(-dy) : 68'(dy);
    b = (t < 0) ? 68'(-t) : 68'(t);
    c = (dx < 0) ? 68'(-dx) : 68'(dx);
    neg = (dy < 0) ^ (t < 0) ^ (dx < 0);
    q = (a * b) / c;
    if (q > (68'd1 << 34)) q = 68'd1 << 34;
    return neg ? sat32(y0 - longint'(q)) : sat32(y0 + longint'(q));
  endfunction

  function automatic pli_pkg::pli_out_t interp_model(longint xq);
    pli_pkg::pli_out_t r;
    int n;
    n = (active_len == 0) ? 1 : (active_len > DEPTH ? DEPTH : active_len);
    r.interp_flag = 1'b1;
    r.y_result = '0;
    for (int i = 0; i < n; i++) begin
      if (xq <= bp_x[i]) begin
        if (xq == bp_x[i]) begin
          r.y_result = 32'(bp_y[i]);
          r.interp_flag = 1'b0;
        end else if (i == 0) begin
          r.y_result = 32'(bp_y[0]);
        end else if (bp_x[i] == bp_x[i-1]) begin
          r.y_result = 32'(bp_y[i-1]);
        end else begin
          r.y_result = 32'(slope_point(bp_y[i-1], bp_y[i] - bp_y[i-1],
                                       xq - bp_x[i-1], bp_x[i] - bp_x[i-1]));
        end
        return r;
      end
      if (i == n - 1) begin
        r.y_result = 32'(bp_y[i]);
        return r;
      end
    end
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(pli_pkg::pli_op_e op, logic [3:0] idx, logic [31:0] xv,
                           logic [31:0] yv);
    pli_pkg::pli_in_t it;
    it.opcode = op;
    it.point_index = idx;
    it.x_value = xv;
    it.y_value = yv;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (in_stall_o);
    if (op == pli_pkg::OP_LOAD) begin
      bp_x[idx] = longint'(signed'(xv));
      bp_y[idx] = longint'(signed'(yv));
      loads_sent++;
    end else begin
      pending_results.insert(pending_results.size(),
                             interp_model(longint'(signed'(xv))));
      queries_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_length(logic [4:0] len);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = len;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    active_len = len;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // kind: 0 ascending, 1 ascending with repeats, 2 unordered, 3 extremes
  task automatic load_table(int kind);
    int xs[DEPTH];
    foreach (xs[i]) xs[i] = (kind == 0 && $urandom_range(0, 1)) ?
                            int'($urandom_range(0, 1 << 22)) - (1 << 21) : int'(rand_word());
    if (kind != 2) xs.sort();
    if (kind == 1)
      for (int i = 1; i < DEPTH; i++) if ($urandom_range(0, 3) == 0) xs[i] = xs[i-1];
    if (kind == 3)
      foreach (xs[i]) xs[i] = (i < DEPTH / 2) ? int'(32'h8000_0000) + i : int'(32'h7fff_fff0) + i;
    for (int i = 0; i < DEPTH; i++)
      send_item(pli_pkg::OP_LOAD, 4'(i), 32'(xs[i]),
                kind == 3 ? ((i % 2) ? 32'h7fff_ffff : 32'h8000_0000) : rand_word());
  endtask

  function automatic logic [31:0] pick_query();
    int n;
    int k;
    longint lo, hi, span;
    n = (active_len == 0) ? 1 : (active_len > DEPTH ? DEPTH : active_len);
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'(bp_x[k]);
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      4, 5: return $urandom;
      default: begin
        if (k == 0) return 32'(bp_x[0] + 1);
        lo = bp_x[k-1] < bp_x[k] ? bp_x[k-1] : bp_x[k];
        hi = bp_x[k-1] < bp_x[k] ? bp_x[k] : bp_x[k-1];
        span = hi - lo + 1;
        return 32'(lo + longint'({$urandom, $urandom} % span));
      end
    endcase
  endfunction

  task automatic test_directed();
    send_item(pli_pkg::OP_LOAD, 4'd0, 32'h0001_0000, 32'h0005_0000);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h0001_0000, 32'h0);
    send_item(pli_pkg::OP_QUERY, 4'd7, 32'h8000_0000, 32'hffff_ffff);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h7fff_ffff, 32'h0);
    write_length(5'd4);
    send_item(pli_pkg::OP_LOAD, 4'd1, 32'h0002_0000, 32'h7fff_ffff);
    send_item(pli_pkg::OP_LOAD, 4'd2, 32'h0002_0000, 32'h8000_0000);
    send_item(pli_pkg::OP_LOAD, 4'd3, 32'h7fff_ffff, 32'h8000_0000);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h0000_8000, 32'h0);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h0001_8000, 32'h0);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h0002_0000, 32'h0);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h0003_0000, 32'h0);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h7fff_ffff, 32'h0);
    send_item(pli_pkg::OP_LOAD, 4'd15, 32'h8000_0000, 32'h7fff_ffff);
    send_item(pli_pkg::OP_LOAD, 4'd0, 32'h8000_0000, 32'h8000_0000);
    send_item(pli_pkg::OP_LOAD, 4'd1, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h0000_0000, 32'h0);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h8000_0001, 32'h0);
    send_item(pli_pkg::OP_QUERY, 4'd0, 32'h7fff_fffe, 32'h0);
  endtask

  task automatic test_length_phase(logic [4:0] len, int kind, int items, bit pause);
    write_length(len);
    load_table(kind);
    for (int i = 0; i < items; i++) begin
      if (pause && i == items / 2) drain_results();
      if ($urandom_range(0, 9) < 2)
        send_item(pli_pkg::OP_LOAD, 4'($urandom_range(0, DEPTH - 1)), rand_word(),
                  rand_word());
      else
        send_item(pli_pkg::OP_QUERY, 4'($urandom), pick_query(), $urandom);
    end
  endtask

  task automatic test_random();
    logic [4:0] lens[8] = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd8, 5'd16, 5'd15};
    for (int p = 0; p < 8; p++)
      test_length_phase(lens[p], p % 4, 180, p == 2);
    for (int p = 0; p < 2; p++)
      test_length_phase(5'($urandom_range(1, 16)), 0, 60, 1'b0);
  endtask

  // receiver stall pattern: none, light or heavy, changing over time
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk_i) begin
    pli_pkg::pli_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result y_result=%h interp_flag=%b",
                 $time, out_data_o.y_result, out_data_o.interp_flag);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data_o.y_result !== want.y_result) begin
          $display("%0t: y_result expected %h actual %h", $time, want.y_result,
                   out_data_o.y_result);
          errors++;
        end
        if (out_data_o.interp_flag !== want.interp_flag) begin
          $display("%0t: interp_flag expected %b actual %b", $time,
                   want.interp_flag, out_data_o.interp_flag);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_results.size());
      $display("piecewise_linear_interp regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    $display("Covered %0d breakpoint loads and %0d queries over lengths 0 to 31;",
             loads_sent, queries_sent);
    $display("%0d results checked, %0d mismatches.", results_checked, errors);
    if (errors == 0)
      $display("piecewise_linear_interp regression: pass");
    else
      $display("piecewise_linear_interp regression: fail");
    $finish;
  end

endmodule
